// ===== sv/esp_pkg.sv =====
`default_nettype none

package esp_pkg;

    // default accumulator width, numbers saturate at all ones
    localparam int NumberBitsDef = 16;

    // result queue depth, two free entries are needed per input byte
    localparam int FifoDepth = 4;

    // characters of the escape grammar
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_BEL      = 8'h07;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_QUESTION = 8'h3F;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_LOWER_H  = 8'h68;
    localparam logic [7:0] CH_LOWER_L  = 8'h6C;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;

    // error codes carried in the number field
    localparam logic [15:0] ERR_BAD_INTRO   = 16'd0;
    localparam logic [15:0] ERR_CSI_PARAM   = 16'd1;
    localparam logic [15:0] ERR_CSI_INTER   = 16'd2;
    localparam logic [15:0] ERR_DEC_NO_ID   = 16'd3;
    localparam logic [15:0] ERR_DEC_TERM    = 16'd4;
    localparam logic [15:0] ERR_OSC_NO_SEMI = 16'd5;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ESC,
        PH_CSI_FIRST,
        PH_CSI_ARGS,
        PH_DEC,
        PH_OSC_ID,
        PH_OSC_PAY,
        PH_OSC_ESC
    } t_phase;

    typedef enum logic [2:0] {
        EV_CSI_ARG    = 3'd0,
        EV_CSI_END    = 3'd1,
        EV_DEC        = 3'd2,
        EV_OSC_START  = 3'd3,
        EV_OSC_BYTE   = 3'd4,
        EV_OSC_VEND   = 3'd5,
        EV_ERROR      = 3'd6
    } t_event;

    // parser control state
    typedef struct packed {
        t_phase phase;
        logic   digits_seen;
        logic   args_seen;
    } t_ctrl;

    // one result item
    typedef struct packed {
        t_event      ev;
        logic [15:0] number;
        logic        flag;
        logic [7:0]  data_byte;
        logic        last;
    } t_result;

    // phase taken when a sequence ends on byte b
    function automatic t_phase idle_phase(input logic [7:0] b);
        return (b == CH_ESC) ? PH_ESC : PH_IDLE;
    endfunction

endpackage

`default_nettype wire

// ===== sv/esp_step.sv =====
`default_nettype none

module esp_step #(
    parameter int NUMBER_BITS = esp_pkg::NumberBitsDef
) (
    input  wire esp_pkg::t_ctrl     i_ctrl,
    input  wire [NUMBER_BITS-1:0]   i_acc,
    input  wire [7:0]               i_byte,
    output esp_pkg::t_ctrl          o_ctrl,
    output logic [NUMBER_BITS-1:0]  o_acc,
    output logic [1:0]              o_count,
    output esp_pkg::t_result        o_res0,
    output esp_pkg::t_result        o_res1
);

    localparam int WideBits = NUMBER_BITS + 4;
    localparam logic [NUMBER_BITS-1:0] NumMax = '1;

    function automatic esp_pkg::t_result mk(
        input esp_pkg::t_event ev,
        input logic [15:0]     number,
        input logic            flag,
        input logic [7:0]      data_byte,
        input logic            last
    );
        esp_pkg::t_result r;
        r.ev        = ev;
        r.number    = number;
        r.flag      = flag;
        r.data_byte = data_byte;
        r.last      = last;
        return r;
    endfunction

    logic                   is_digit;
    logic [WideBits-1:0]    acc_ext;
    logic [WideBits-1:0]    acc_sum;
    logic [NUMBER_BITS-1:0] acc_dig;
    logic [15:0]            arg_num;
    esp_pkg::t_ctrl         idle_ctrl;
    esp_pkg::t_ctrl         done_ctrl;
    esp_pkg::t_result       arg_res;
    esp_pkg::t_result       none_res;

    // decimal digit accumulate with saturation
    assign is_digit = (i_byte >= esp_pkg::CH_ZERO) && (i_byte <= esp_pkg::CH_NINE);
    assign acc_ext  = WideBits'(i_acc);
    assign acc_sum  = (acc_ext << 3) + (acc_ext << 1) + WideBits'(i_byte[3:0]);
    assign acc_dig  = (acc_sum > WideBits'(NumMax)) ? NumMax : acc_sum[NUMBER_BITS-1:0];

    assign arg_num   = i_ctrl.digits_seen ? 16'(i_acc) : 16'd0;
    assign arg_res   = mk(esp_pkg::EV_CSI_ARG, arg_num, i_ctrl.digits_seen, 8'd0, 1'b0);
    assign none_res  = mk(esp_pkg::EV_CSI_ARG, 16'd0, 1'b0, 8'd0, 1'b0);
    assign idle_ctrl = '{phase: esp_pkg::idle_phase(i_byte), digits_seen: 1'b0,
                         args_seen: 1'b0};
    assign done_ctrl = '{phase: esp_pkg::PH_IDLE, digits_seen: 1'b0, args_seen: 1'b0};

    // osc payload byte handling
    logic             pay_valid;
    esp_pkg::t_phase  pay_phase;
    esp_pkg::t_result pay_res;

    always_comb begin
        pay_valid = 1'b1;
        pay_phase = esp_pkg::PH_OSC_PAY;
        pay_res   = mk(esp_pkg::EV_OSC_BYTE, 16'd0, 1'b0, i_byte, 1'b0);
        if (i_byte == esp_pkg::CH_SEMI) begin
            pay_res = mk(esp_pkg::EV_OSC_VEND, 16'd0, 1'b0, 8'd0, 1'b0);
        end else if (i_byte == esp_pkg::CH_BEL) begin
            pay_res   = mk(esp_pkg::EV_OSC_VEND, 16'd0, 1'b0, 8'd0, 1'b1);
            pay_phase = esp_pkg::PH_IDLE;
        end else if (i_byte == esp_pkg::CH_ESC) begin
            pay_valid = 1'b0;
            pay_phase = esp_pkg::PH_OSC_ESC;
        end
    end

    // csi argument and final byte handling
    esp_pkg::t_ctrl         csi_ctrl;
    logic [NUMBER_BITS-1:0] csi_acc;
    logic [1:0]             csi_count;
    esp_pkg::t_result       csi_res0;
    esp_pkg::t_result       csi_res1;
    logic                   csi_trail;
    esp_pkg::t_result       csi_end;

    always_comb begin
        csi_ctrl       = i_ctrl;
        csi_ctrl.phase = esp_pkg::PH_CSI_ARGS;
        csi_acc        = i_acc;
        csi_count      = 2'd0;
        csi_res0       = none_res;
        csi_res1       = none_res;
        csi_trail      = i_ctrl.digits_seen || i_ctrl.args_seen;
        if ((i_byte >= 8'h40) && (i_byte <= 8'h7E)) begin
            csi_end = mk(esp_pkg::EV_CSI_END, 16'd0, 1'b1, i_byte, 1'b1);
        end else begin
            csi_end = mk(esp_pkg::EV_CSI_END, 16'd0, 1'b0, 8'd0, 1'b1);
        end
        if (is_digit) begin
            csi_acc              = acc_dig;
            csi_ctrl.digits_seen = 1'b1;
        end else if (i_byte == esp_pkg::CH_SEMI) begin
            csi_res0  = arg_res;
            csi_count = 2'd1;
            csi_acc   = '0;
            csi_ctrl  = '{phase: esp_pkg::PH_CSI_ARGS, digits_seen: 1'b0, args_seen: 1'b1};
        end else if ((i_byte >= 8'h30) && (i_byte <= 8'h3F)) begin
            csi_res0  = mk(esp_pkg::EV_ERROR, esp_pkg::ERR_CSI_PARAM, 1'b0, 8'd0, 1'b1);
            csi_count = 2'd1;
            csi_acc   = '0;
            csi_ctrl  = idle_ctrl;
        end else if ((i_byte >= 8'h20) && (i_byte <= 8'h2F)) begin
            csi_res0  = mk(esp_pkg::EV_ERROR, esp_pkg::ERR_CSI_INTER, 1'b0, 8'd0, 1'b1);
            csi_count = 2'd1;
            csi_acc   = '0;
            csi_ctrl  = idle_ctrl;
        end else begin
            // trailing argument goes first when present
            if (csi_trail) begin
                csi_res0  = arg_res;
                csi_res1  = csi_end;
                csi_count = 2'd2;
            end else begin
                csi_res0  = csi_end;
                csi_count = 2'd1;
            end
            csi_acc = '0;
            // a final byte is consumed, any other byte starts over as idle input
            csi_ctrl = csi_end.flag ? done_ctrl : idle_ctrl;
        end
    end

    // next state and results per phase
    always_comb begin
        o_ctrl  = i_ctrl;
        o_acc   = i_acc;
        o_count = 2'd0;
        o_res0  = none_res;
        o_res1  = none_res;
        unique case (i_ctrl.phase)
            esp_pkg::PH_IDLE: begin
                o_ctrl = idle_ctrl;
                o_acc  = '0;
            end
            esp_pkg::PH_ESC: begin
                o_acc  = '0;
                o_ctrl = '{phase: esp_pkg::PH_IDLE, digits_seen: 1'b0, args_seen: 1'b0};
                if (i_byte == esp_pkg::CH_LBRACKET) begin
                    o_ctrl.phase = esp_pkg::PH_CSI_FIRST;
                end else if (i_byte == esp_pkg::CH_RBRACKET) begin
                    o_ctrl.phase = esp_pkg::PH_OSC_ID;
                end else begin
                    o_res0  = mk(esp_pkg::EV_ERROR, esp_pkg::ERR_BAD_INTRO, 1'b0, 8'd0, 1'b1);
                    o_count = 2'd1;
                    o_ctrl  = idle_ctrl;
                end
            end
            esp_pkg::PH_CSI_FIRST: begin
                if (i_byte == esp_pkg::CH_QUESTION) begin
                    o_acc              = '0;
                    o_ctrl.digits_seen = 1'b0;
                    o_ctrl.phase       = esp_pkg::PH_DEC;
                end else begin
                    o_ctrl  = csi_ctrl;
                    o_acc   = csi_acc;
                    o_count = csi_count;
                    o_res0  = csi_res0;
                    o_res1  = csi_res1;
                end
            end
            esp_pkg::PH_CSI_ARGS: begin
                o_ctrl  = csi_ctrl;
                o_acc   = csi_acc;
                o_count = csi_count;
                o_res0  = csi_res0;
                o_res1  = csi_res1;
            end
            esp_pkg::PH_DEC: begin
                if (is_digit) begin
                    o_acc              = acc_dig;
                    o_ctrl.digits_seen = 1'b1;
                end else if (!i_ctrl.digits_seen) begin
                    o_res0  = mk(esp_pkg::EV_ERROR, esp_pkg::ERR_DEC_NO_ID, 1'b0, 8'd0, 1'b1);
                    o_count = 2'd1;
                    o_acc   = '0;
                    o_ctrl  = idle_ctrl;
                end else if ((i_byte == esp_pkg::CH_LOWER_H)
                             || (i_byte == esp_pkg::CH_LOWER_L)) begin
                    o_res0  = mk(esp_pkg::EV_DEC, 16'(i_acc),
                                 i_byte == esp_pkg::CH_LOWER_H, 8'd0, 1'b1);
                    o_count = 2'd1;
                    o_acc   = '0;
                    o_ctrl  = done_ctrl;
                end else begin
                    o_res0  = mk(esp_pkg::EV_ERROR, esp_pkg::ERR_DEC_TERM, 1'b0, 8'd0, 1'b1);
                    o_count = 2'd1;
                    o_acc   = '0;
                    o_ctrl  = idle_ctrl;
                end
            end
            esp_pkg::PH_OSC_ID: begin
                if (is_digit) begin
                    o_acc              = acc_dig;
                    o_ctrl.digits_seen = 1'b1;
                end else if (i_byte != esp_pkg::CH_SEMI) begin
                    o_res0  = mk(esp_pkg::EV_ERROR, esp_pkg::ERR_OSC_NO_SEMI,
                                 1'b0, 8'd0, 1'b1);
                    o_count = 2'd1;
                    o_acc   = '0;
                    o_ctrl  = idle_ctrl;
                end else begin
                    o_res0  = mk(esp_pkg::EV_OSC_START, arg_num, i_ctrl.digits_seen,
                                 8'd0, 1'b0);
                    o_count = 2'd1;
                    o_acc   = '0;
                    o_ctrl  = '{phase: esp_pkg::PH_OSC_PAY, digits_seen: 1'b0,
                                args_seen: i_ctrl.args_seen};
                end
            end
            esp_pkg::PH_OSC_PAY: begin
                o_res0       = pay_res;
                o_count      = {1'b0, pay_valid};
                o_ctrl.phase = pay_phase;
            end
            esp_pkg::PH_OSC_ESC: begin
                if (i_byte == esp_pkg::CH_BSLASH) begin
                    o_res0  = mk(esp_pkg::EV_OSC_VEND, 16'd0, 1'b0, 8'd0, 1'b1);
                    o_count = 2'd1;
                    o_acc   = '0;
                    o_ctrl  = done_ctrl;
                end else begin
                    // held escape turns out to be payload
                    o_res0       = mk(esp_pkg::EV_OSC_BYTE, 16'd0, 1'b0,
                                      esp_pkg::CH_ESC, 1'b0);
                    o_res1       = pay_res;
                    o_count      = pay_valid ? 2'd2 : 2'd1;
                    o_ctrl.phase = pay_phase;
                end
            end
            default: begin
                o_ctrl = idle_ctrl;
                o_acc  = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/escape_sequence_parser.sv =====
// output: a result is registered in the result queue when its byte is accepted
// throughput: one byte per cycle while input ready is high; a byte may yield two results
// a four-entry result queue absorbs those; input ready drops with fewer than two free
// reset: synchronous active-low i_rst_n clears the parser state and empties the queue
// the input side becomes ready the cycle after reset is released
`default_nettype none

module escape_sequence_parser #(
    parameter int NUMBER_BITS = esp_pkg::NumberBitsDef
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,   // [7:0] in_byte
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [15:0] number, [16] flag, [24:17] data_byte
    output logic [2:0]  o_m_axis_tuser,   // [2:0] event_res
    output logic        o_m_axis_tlast
);

    localparam int PtrW = $clog2(esp_pkg::FifoDepth);
    localparam int CntW = $clog2(esp_pkg::FifoDepth + 1);

    logic                   s_accept;
    logic                   m_pop;
    esp_pkg::t_ctrl         r_ctrl;
    esp_pkg::t_ctrl         n_ctrl;
    logic [NUMBER_BITS-1:0] r_acc;
    logic [NUMBER_BITS-1:0] n_acc;
    logic [1:0]             step_count;
    esp_pkg::t_result       step_res0;
    esp_pkg::t_result       step_res1;
    logic [1:0]             push_count;
    logic                   r_run;

    esp_pkg::t_result       r_fifo [esp_pkg::FifoDepth];
    logic [PtrW-1:0]        r_wr_ptr;
    logic [PtrW-1:0]        r_rd_ptr;
    logic [CntW-1:0]        r_count;
    logic [PtrW-1:0]        wr_ptr1;
    esp_pkg::t_result       head;

    // transaction handshakes
    assign s_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign m_pop      = o_m_axis_tvalid && i_m_axis_tready;
    assign push_count = s_accept ? step_count : 2'd0;

    // parser next-state logic
    esp_step #(
        .NUMBER_BITS (NUMBER_BITS)
    ) u_step (
        .i_ctrl  (r_ctrl),
        .i_acc   (r_acc),
        .i_byte  (i_s_axis_tdata),
        .o_ctrl  (n_ctrl),
        .o_acc   (n_acc),
        .o_count (step_count),
        .o_res0  (step_res0),
        .o_res1  (step_res1)
    );

    // parser state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '{phase: esp_pkg::PH_IDLE, digits_seen: 1'b0, args_seen: 1'b0};
            r_acc  <= '0;
            r_run  <= 1'b0;
        end else begin
            r_run <= 1'b1;
            if (s_accept) begin
                r_ctrl <= n_ctrl;
                r_acc  <= n_acc;
            end
        end
    end

    // result queue storage
    assign wr_ptr1 = r_wr_ptr + PtrW'(1);

    always_ff @(posedge i_clk) begin
        if (push_count != 2'd0) begin
            r_fifo[r_wr_ptr] <= step_res0;
        end
        if (push_count == 2'd2) begin
            r_fifo[wr_ptr1] <= step_res1;
        end
    end

    // result queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PtrW'(push_count);
            r_rd_ptr <= r_rd_ptr + PtrW'(m_pop);
            r_count  <= r_count + CntW'(push_count) - CntW'(m_pop);
        end
    end

    // ports
    assign head            = r_fifo[r_rd_ptr];
    assign o_s_axis_tready = r_run && (r_count <= CntW'(esp_pkg::FifoDepth - 2));
    assign o_m_axis_tvalid = (r_count != '0);
    assign o_m_axis_tdata  = {7'd0, head.data_byte, head.flag, head.number};
    assign o_m_axis_tuser  = head.ev;
    assign o_m_axis_tlast  = head.last;

    // queue never overfills
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(esp_pkg::FifoDepth))
        else $error("result queue overflow");

    // fill count tracks pushes and pops
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
            r_count == CntW'($past(r_count) + CntW'($past(push_count))
                             - CntW'($past(m_pop))))
        else $error("result queue count mismatch");

    // idle phase holds a cleared number
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctrl.phase == esp_pkg::PH_IDLE |->
            (r_acc == '0) && !r_ctrl.digits_seen && !r_ctrl.args_seen)
        else $error("number not cleared in idle");

    // an error always drops out of the sequence
    a_error_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && (step_count != 2'd0) && (step_res0.ev == esp_pkg::EV_ERROR) |=>
            (r_ctrl.phase == esp_pkg::PH_IDLE) || (r_ctrl.phase == esp_pkg::PH_ESC))
        else $error("error did not end the sequence");

endmodule

`default_nettype wire
